[hw/rtl/brm_pkg.sv]
// Shared types and codes for the banked ROM mapper with interrupt counter.
// Used by banked_rom_mapper_with_irq_counter_unit; no dependencies.
`default_nettype none

package brm_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_PRG   = 2'd2;
    localparam logic [1:0] OP_CHR   = 2'd3;

    // Write register groups, address bits 14..12 with bit 15 set
    localparam logic [2:0] WR_PRG0   = 3'd0;
    localparam logic [2:0] WR_MIRROR = 3'd1;
    localparam logic [2:0] WR_PRG1   = 3'd2;
    localparam logic [2:0] WR_CHR_LO = 3'd3;
    localparam logic [2:0] WR_CHR_HI = 3'd4;
    localparam logic [2:0] WR_RLD_LO = 3'd5;
    localparam logic [2:0] WR_IRQ_E  = 3'd6;
    localparam logic [2:0] WR_IRQ_F  = 3'd7;

    // Configuration register indexes (byte address bits 3..2)
    localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [1:0] CFG_FOUR_SCR  = 2'd2;

    localparam logic [7:0] PRG_COUNT_RESET = 8'd2;
    localparam logic [2:0] MIRROR_FOUR     = 3'd4;
    localparam logic [7:0] TICK_WRAP       = 8'hFF;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data;
        logic [15:0] cycles;
    } in_item_t;

    typedef struct packed {
        logic [7:0] bank;
        logic [2:0] mirror_mode;
        logic       irq_raise;
        logic       irq_clear;
    } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/banked_rom_mapper_with_irq_counter_unit.sv]
// Banked ROM mapper with cycle-driven interrupt counter, top level.
// Depends on brm_pkg for payload structs and operation codes.
//
//   channel  | direction | handshake               | payload
//   in       | input     | in_valid / in_stall     | in_item  (in_item_t)
//   out      | output    | out_valid / out_stall   | out_item (out_item_t)
//   config   | input     | psel/penable/pwrite     | paddr, pwdata, prdata
//
// Writes, ticks and lookups that need no modulo go from ST_IDLE to ST_DONE.
// A lookup that reduces a select register modulo the bank count passes through ST_DIV:
// one shared 9-bit subtract/compare unit runs one quotient bit per cycle.
// in_stall is high from acceptance until the result moves to the output
// register; the output register lets the next item start while a result waits.
// Reset clears all mapper state; the program bank count resets to 2.
`default_nettype none

module banked_rom_mapper_with_irq_counter_unit
    import brm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_item,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_item,
    input  wire logic       psel,
    input  wire logic       penable,
    input  wire logic       pwrite,
    input  wire logic [3:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t      state_reg, state_next;

    logic [7:0]  prg_count_reg;
    logic [7:0]  chr_count_reg;
    logic        four_screen_reg;

    logic [4:0]  prg_sel_reg [2];
    logic [4:0]  prg_sel_next [2];
    logic [7:0]  chr_sel_reg [8];
    logic [7:0]  chr_sel_next [8];
    logic [1:0]  mirroring_reg, mirroring_next;
    logic        irq_en_reg, irq_en_next;
    logic [7:0]  reload_reg, reload_next;
    logic [7:0]  tick_reg, tick_next;

    // Modulo unit: remainder, shifting dividend, divisor, step counter
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  dvd_reg, dvd_next;
    logic [7:0]  dvs_reg, dvs_next;
    logic [2:0]  step_reg, step_next;

    logic [7:0]  bank_reg, bank_next;
    logic        raise_reg, raise_next;
    logic        clear_reg, clear_next;

    logic        out_valid_reg, out_valid_next;
    out_item_t   out_item_reg, out_item_next;

    logic        cfg_wr;
    logic [8:0]  trial;
    logic [8:0]  diff;
    logic [7:0]  tick_sum;
    logic [2:0]  chr_slot;
    logic [2:0]  chr_win;
    logic [7:0]  lookup_val;

    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        case (paddr[3:2])
            CFG_PRG_COUNT: prdata = {24'd0, prg_count_reg};
            CFG_CHR_COUNT: prdata = {24'd0, chr_count_reg};
            CFG_FOUR_SCR:  prdata = {31'd0, four_screen_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign trial    = {rem_reg, dvd_reg[7]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign tick_sum = tick_reg + in_item.cycles[7:0];
    assign chr_slot = {in_item.address[14:12] == WR_CHR_HI, in_item.address[2:1]};
    assign chr_win  = in_item.address[12:10];

    always_comb
    begin
        state_next     = state_reg;
        prg_sel_next   = prg_sel_reg;
        chr_sel_next   = chr_sel_reg;
        mirroring_next = mirroring_reg;
        irq_en_next    = irq_en_reg;
        reload_next    = reload_reg;
        tick_next      = tick_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        step_next      = step_reg;
        bank_next      = bank_reg;
        raise_next     = raise_reg;
        clear_next     = clear_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        lookup_val     = 8'd0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bank_next  = 8'd0;
                    raise_next = 1'b0;
                    clear_next = 1'b0;
                    state_next = ST_DONE;
                    case (in_item.opcode)
                        OP_WRITE:
                        begin
                            if (in_item.address[15])
                            begin
                                case (in_item.address[14:12])
                                    WR_PRG0: prg_sel_next[0] = in_item.data[4:0];
                                    WR_MIRROR:
                                    begin
                                        if (!in_item.address[1])
                                        begin
                                            mirroring_next = in_item.data[1:0];
                                        end
                                    end
                                    WR_PRG1: prg_sel_next[1] = in_item.data[4:0];
                                    WR_CHR_LO, WR_CHR_HI:
                                    begin
                                        if (in_item.address[0])
                                        begin
                                            chr_sel_next[chr_slot][7:4] = in_item.data[3:0];
                                        end
                                        else
                                        begin
                                            chr_sel_next[chr_slot][3:0] = in_item.data[3:0];
                                        end
                                    end
                                    WR_RLD_LO: reload_next[3:0] = in_item.data[3:0];
                                    WR_IRQ_E:
                                    begin
                                        if (!in_item.address[1])
                                        begin
                                            reload_next[7:4] = in_item.data[3:0];
                                        end
                                        else
                                        begin
                                            irq_en_next = in_item.data[1];
                                            if (in_item.data[1])
                                            begin
                                                tick_next = reload_reg;
                                            end
                                            else
                                            begin
                                                clear_next = 1'b1;
                                            end
                                        end
                                    end
                                    WR_IRQ_F:
                                    begin
                                        irq_en_next = in_item.data[0];
                                        clear_next  = 1'b1;
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        OP_TICK:
                        begin
                            if (irq_en_reg)
                            begin
                                if (tick_sum == TICK_WRAP)
                                begin
                                    tick_next  = reload_reg;
                                    raise_next = 1'b1;
                                end
                                else
                                begin
                                    tick_next = tick_sum;
                                end
                            end
                        end
                        OP_PRG:
                        begin
                            if (in_item.address[15])
                            begin
                                if (in_item.address[14])
                                begin
                                    // fixed windows: last two banks
                                    bank_next = prg_count_reg
                                              - (in_item.address[13] ? 8'd1 : 8'd2);
                                end
                                else
                                begin
                                    lookup_val = {3'd0, prg_sel_reg[in_item.address[13]]};
                                    if (prg_count_reg == 8'd0)
                                    begin
                                        bank_next = lookup_val;
                                    end
                                    else
                                    begin
                                        dvs_next   = prg_count_reg;
                                        state_next = ST_DIV;
                                    end
                                end
                            end
                        end
                        OP_CHR:
                        begin
                            if (in_item.address[15:13] == 3'd0)
                            begin
                                lookup_val = chr_sel_reg[chr_win];
                                if (chr_count_reg == 8'd0)
                                begin
                                    bank_next = {5'd0, chr_win};
                                end
                                else
                                begin
                                    dvs_next   = chr_count_reg;
                                    state_next = ST_DIV;
                                end
                            end
                        end
                        default: ;
                    endcase
                    // seed the modulo unit; used only when entering ST_DIV
                    dvd_next  = lookup_val;
                    rem_next  = 8'd0;
                    step_next = 3'd7;
                end
            end
            ST_DIV:
            begin
                // one restoring step: shift in a dividend bit, subtract if it fits
                dvd_next = {dvd_reg[6:0], 1'b0};
                if (!diff[8])
                begin
                    rem_next = diff[7:0];
                end
                else
                begin
                    rem_next = trial[7:0];
                end
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    bank_next  = rem_next;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_item_next.bank        = bank_reg;
                    out_item_next.mirror_mode = four_screen_reg ? MIRROR_FOUR
                                                                : {1'b0, mirroring_reg};
                    out_item_next.irq_raise   = raise_reg;
                    out_item_next.irq_clear   = clear_reg;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            prg_count_reg   <= PRG_COUNT_RESET;
            chr_count_reg   <= 8'd0;
            four_screen_reg <= 1'b0;
            prg_sel_reg     <= '{default: 5'd0};
            chr_sel_reg     <= '{default: 8'd0};
            mirroring_reg   <= 2'd0;
            irq_en_reg      <= 1'b0;
            reload_reg      <= 8'd0;
            tick_reg        <= 8'd0;
            rem_reg         <= 8'd0;
            dvd_reg         <= 8'd0;
            dvs_reg         <= 8'd0;
            step_reg        <= 3'd0;
            bank_reg        <= 8'd0;
            raise_reg       <= 1'b0;
            clear_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_item_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            prg_sel_reg   <= prg_sel_next;
            chr_sel_reg   <= chr_sel_next;
            mirroring_reg <= mirroring_next;
            irq_en_reg    <= irq_en_next;
            reload_reg    <= reload_next;
            tick_reg      <= tick_next;
            rem_reg       <= rem_next;
            dvd_reg       <= dvd_next;
            dvs_reg       <= dvs_next;
            step_reg      <= step_next;
            bank_reg      <= bank_next;
            raise_reg     <= raise_next;
            clear_reg     <= clear_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    CFG_PRG_COUNT: prg_count_reg   <= pwdata[7:0];
                    CFG_CHR_COUNT: chr_count_reg   <= pwdata[7:0];
                    CFG_FOUR_SCR:  four_screen_reg <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
